// ===== rtl/core/maa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// maa_pkg
// Shared constants for the modular arithmetic unit.
// ----------------------------------------------------------------------------
package maa_pkg;

  localparam int unsigned VAL_W = 31;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned EXP_W = 64;
  localparam int unsigned CNT_W = 5;
  // Euclid coefficients and the q*v product stay within about two moduli
  localparam int unsigned COEF_W = 34;
  localparam int unsigned PROD_W = 35;

  localparam logic [VAL_W-1:0] MOD_RESET = 31'd1000000007;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd3;
  localparam logic [OP_W-1:0] OP_NEG    = 3'd4;
  localparam logic [OP_W-1:0] OP_INV    = 3'd5;
  localparam logic [OP_W-1:0] OP_POW    = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam logic [CNT_W-1:0] LAST_STEP = 5'd30;

endpackage
`default_nettype wire

// ===== rtl/core/maa_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// maa_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module maa_mulmod
  import maa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [VAL_W-1:0] x,
  input  wire logic [VAL_W-1:0] y,
  input  wire logic [VAL_W-1:0] m,
  output logic                  done,
  output logic      [VAL_W-1:0] p
);

  logic [VAL_W-1:0] xr;
  logic [VAL_W-1:0] yr;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [VAL_W+1:0] t0;
  logic [VAL_W+1:0] t1;
  logic [VAL_W+1:0] t2;
  logic [VAL_W+1:0] mx;

  // acc < m and x < m, so 2*acc + x < 3m: two trial subtracts
  always_comb begin
    mx = {2'b00, m};
    t0 = {1'b0, p, 1'b0} + (yr[VAL_W-1] ? {2'b00, xr} : '0);
    t1 = (t0 >= mx) ? t0 - mx : t0;
    t2 = (t1 >= mx) ? t1 - mx : t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        xr  <= x;
        yr  <= y;
        p   <= '0;
      end else if (run) begin
        p   <= t2[VAL_W-1:0];
        yr  <= {yr[VAL_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/maa_divstep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// maa_divstep
// Restoring divider for one Euclid round: remainder of a/b and q*v,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module maa_divstep
  import maa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic        [VAL_W-1:0]  a,
  input  wire logic        [VAL_W-1:0]  b,
  input  wire logic signed [COEF_W-1:0] v,
  output logic                          done,
  output logic             [VAL_W-1:0]  rem,
  output logic signed      [PROD_W-1:0] qv
);

  logic        [VAL_W-1:0]  ar;
  logic        [VAL_W-1:0]  br;
  logic signed [PROD_W-1:0] vx;
  logic        [CNT_W-1:0]  cnt;
  logic                     run;
  logic        [VAL_W:0]    t;
  logic                     qbit;

  always_comb begin
    t    = {rem, ar[VAL_W-1]};
    qbit = (t >= {1'b0, br});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        ar  <= a;
        br  <= b;
        vx  <= {v[COEF_W-1], v};
        rem <= '0;
        qv  <= '0;
      end else if (run) begin
        rem <= qbit ? VAL_W'(t - {1'b0, br}) : t[VAL_W-1:0];
        // accumulate q*v MSB first alongside the quotient
        qv  <= (qv <<< 1) + (qbit ? vx : '0);
        ar  <= {ar[VAL_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/modular_arithmetic_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_arithmetic_alu
// Modular add, sub, mul, div, neg, inverse and pow under a set modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode, operand_a, operand_b, exponent and raise start while busy
//   is low; the word is taken at that edge. Exactly one result word appears
//   on result/operand_error with done high for one cycle; the receiver must
//   take it then, it cannot stall.
//   modulus is written through modulus_valid/modulus_ready; ready is high
//   only while the unit is idle.
// Sequencing:
//   add, sub, neg, out-of-range operands, unused opcode: result in the
//   cycle after the word is taken. mul: one pass of the bit-serial multiplier.
//   inverse: one divider pass plus a handoff per Euclid round, up
//   to about 45 rounds; div adds one multiplier pass.
//   pow: one multiplier pass each for one square per exponent bit up to
//   the highest set one plus one multiply per set bit: up to 128 passes
//   for a 64-bit exponent.
//   One word is in flight at a time; busy is high until done.
// Reset: synchronous, restores modulus to 1000000007 and idles the unit.
// ----------------------------------------------------------------------------
module modular_arithmetic_alu
  import maa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [OP_W-1:0]  opcode,
  input  wire logic [VAL_W-1:0] operand_a,
  input  wire logic [VAL_W-1:0] operand_b,
  input  wire logic [EXP_W-1:0] exponent,
  output logic                  done,
  output logic      [VAL_W-1:0] result,
  output logic                  operand_error,
  input  wire logic             modulus_valid,
  output logic                  modulus_ready,
  input  wire logic [VAL_W-1:0] modulus
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EUC    = 3'd1;
  localparam logic [2:0] S_EUC_W  = 3'd2;
  localparam logic [2:0] S_MUL_W  = 3'd3;
  localparam logic [2:0] S_POW    = 3'd4;
  localparam logic [2:0] S_POW_MW = 3'd5;
  localparam logic [2:0] S_POW_SW = 3'd6;

  logic [2:0]              state;
  logic [VAL_W-1:0]        m;
  logic [OP_W-1:0]         op;
  logic [VAL_W-1:0]        ar;
  logic [EXP_W-1:0]        k;
  logic [VAL_W-1:0]        pr;
  logic [VAL_W-1:0]        base;
  logic [VAL_W-1:0]        ea;
  logic [VAL_W-1:0]        eb;
  logic signed [COEF_W-1:0] u;
  logic signed [COEF_W-1:0] v;

  logic             mul_go;
  logic [VAL_W-1:0] mul_x;
  logic [VAL_W-1:0] mul_y;
  logic             mul_done;
  logic [VAL_W-1:0] mul_p;

  logic                     div_go;
  logic                     div_done;
  logic [VAL_W-1:0]         div_rem;
  logic signed [PROD_W-1:0] div_qv;

  logic             accept;
  logic             err;
  logic [VAL_W:0]   sum_ab;
  logic [VAL_W:0]   sum_sub;
  logic [VAL_W:0]   mw;
  logic signed [COEF_W:0] u_f0;
  logic signed [COEF_W:0] u_f1;
  logic [VAL_W-1:0] inv;
  logic signed [PROD_W-1:0] nu;

  assign busy          = (state != S_IDLE);
  assign modulus_ready = !busy;
  assign accept        = start && !busy;

  always_comb begin
    mw      = {1'b0, m};
    err     = 1'b0;
    if (opcode != OP_UNUSED) begin
      err = (operand_a >= m) ||
            ((opcode <= OP_DIV) && (operand_b >= m));
    end
    sum_ab  = {1'b0, operand_a} + {1'b0, operand_b};
    sum_ab  = (sum_ab >= mw) ? sum_ab - mw : sum_ab;
    sum_sub = {1'b0, operand_a} + (mw - {1'b0, operand_b});
    sum_sub = (sum_sub >= mw) ? sum_sub - mw : sum_sub;
    // fold the Bezout coefficient into [0, m)
    u_f0    = u[COEF_W-1] ? {u[COEF_W-1], u} + (COEF_W+1)'(m) : {u[COEF_W-1], u};
    u_f1    = (u_f0 >= (COEF_W+1)'(m)) ? u_f0 - (COEF_W+1)'(m) : u_f0;
    inv     = u_f1[VAL_W-1:0];
    nu      = {u[COEF_W-1], u} - div_qv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      m      <= MOD_RESET;
      done   <= 1'b0;
      mul_go <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      mul_go <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (modulus_valid) begin
            m <= modulus;
          end
          if (accept) begin
            op <= opcode;
            ar <= operand_a;
            operand_error <= err;
            result <= '0;
            if (err) begin
              done <= 1'b1;
            end else begin
              case (opcode) inside
                OP_ADD: begin
                  result <= sum_ab[VAL_W-1:0];
                  done   <= 1'b1;
                end
                OP_SUB: begin
                  result <= sum_sub[VAL_W-1:0];
                  done   <= 1'b1;
                end
                OP_NEG: begin
                  result <= (operand_a == '0) ? '0 : m - operand_a;
                  done   <= 1'b1;
                end
                OP_MUL: begin
                  mul_go <= 1'b1;
                  mul_x  <= operand_a;
                  mul_y  <= operand_b;
                  state  <= S_MUL_W;
                end
                OP_DIV, OP_INV: begin
                  ea    <= (opcode == OP_DIV) ? operand_b : operand_a;
                  eb    <= m;
                  u     <= COEF_W'(1);
                  v     <= '0;
                  state <= S_EUC;
                end
                OP_POW: begin
                  pr    <= (m == VAL_W'(1)) ? '0 : VAL_W'(1);
                  base  <= operand_a;
                  k     <= exponent;
                  state <= S_POW;
                end
                default: begin
                  done <= 1'b1;
                end
              endcase
            end
          end
        end
        S_EUC: begin
          if (eb == '0) begin
            if (op == OP_DIV) begin
              mul_go <= 1'b1;
              mul_x  <= ar;
              mul_y  <= inv;
              state  <= S_MUL_W;
            end else begin
              result <= inv;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end else begin
            div_go <= 1'b1;
            state  <= S_EUC_W;
          end
        end
        S_EUC_W: begin
          if (div_done) begin
            ea    <= eb;
            eb    <= div_rem;
            u     <= v;
            v     <= nu[COEF_W-1:0];
            state <= S_EUC;
          end
        end
        S_MUL_W: begin
          if (mul_done) begin
            result <= mul_p;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_POW: begin
          if (k == '0) begin
            result <= pr;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (k[0]) begin
            mul_go <= 1'b1;
            mul_x  <= pr;
            mul_y  <= base;
            state  <= S_POW_MW;
          end else begin
            mul_go <= 1'b1;
            mul_x  <= base;
            mul_y  <= base;
            state  <= S_POW_SW;
          end
        end
        S_POW_MW: begin
          if (mul_done) begin
            pr     <= mul_p;
            mul_go <= 1'b1;
            mul_x  <= base;
            mul_y  <= base;
            state  <= S_POW_SW;
          end
        end
        S_POW_SW: begin
          if (mul_done) begin
            base  <= mul_p;
            k     <= k >> 1;
            state <= S_POW;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  maa_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .x    (mul_x),
    .y    (mul_y),
    .m    (m),
    .done (mul_done),
    .p    (mul_p)
  );

  maa_divstep u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .a    (ea),
    .b    (eb),
    .v    (v),
    .done (div_done),
    .rem  (div_rem),
    .qv   (div_qv)
  );

endmodule
`default_nettype wire

// ===== tb/sv/modular_arithmetic_alu_check.sv =====
// ----------------------------------------------------------------------------
// modular_arithmetic_alu_check
// Watches the command, result and modulus channels of the modular ALU,
// predicts every result word from a shadow of the modulus register and
// compares each strobed result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module modular_arithmetic_alu_check
  import maa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [OP_W-1:0]  opcode,
  input  logic [VAL_W-1:0] operand_a,
  input  logic [VAL_W-1:0] operand_b,
  input  logic [EXP_W-1:0] exponent,
  input  logic             done,
  input  logic [VAL_W-1:0] result,
  input  logic             operand_error,
  input  logic             modulus_valid,
  input  logic             modulus_ready,
  input  logic [VAL_W-1:0] modulus,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             err;
  } alu_word_t;

  alu_word_t        pending_words[$];
  logic [VAL_W-1:0] mod_shadow;
  int               mismatches;

  assign fail_count  = mismatches;
  assign outstanding = pending_words.size();

  function automatic longint unsigned inverse_mod(longint unsigned x, longint unsigned m);
    longint a, b, u, v, q, t, r;
    a = longint'(x);
    b = longint'(m);
    u = 1;
    v = 0;
    while (b != 0) begin
      q = a / b;
      a = a - q * b;
      t = a; a = b; b = t;
      u = u - q * v;
      t = u; u = v; v = t;
    end
    r = u % longint'(m);
    if (r < 0) r = r + longint'(m);
    return unsigned'(r);
  endfunction

  function automatic longint unsigned power_mod(longint unsigned base,
                                                logic [EXP_W-1:0] k,
                                                longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    for (int i = 0; i < EXP_W; i++) begin
      if (k[i]) r = (r * base) % m;
      base = (base * base) % m;
    end
    return r;
  endfunction

  function automatic alu_word_t compute_word(logic [OP_W-1:0] op, logic [VAL_W-1:0] a_in,
                                             logic [VAL_W-1:0] b_in, logic [EXP_W-1:0] k,
                                             logic [VAL_W-1:0] m_in);
    alu_word_t       w;
    longint unsigned a, b, m, r;
    a = 64'(a_in);
    b = 64'(b_in);
    m = 64'(m_in);
    r = 0;
    w.err = 1'b0;
    if (op != OP_UNUSED) begin
      if (a >= m || (op <= OP_DIV && b >= m)) w.err = 1'b1;
    end
    if (!w.err) begin
      case (op)
        OP_ADD: begin
          r = a + b;
          if (r >= m) r = r - m;
        end
        OP_SUB: begin
          r = a + (m - b);
          if (r >= m) r = r - m;
        end
        OP_MUL: r = (a * b) % m;
        OP_DIV: r = (a * inverse_mod(b, m)) % m;
        OP_NEG: r = (a == 0) ? 0 : m - a;
        OP_INV: r = inverse_mod(a, m);
        OP_POW: r = power_mod(a, k, m);
        default: r = 0;
      endcase
    end
    w.value = r[VAL_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    alu_word_t want;
    if (rst) begin
      mod_shadow = MOD_RESET;
      pending_words.delete();
      mismatches = 0;
    end else begin
      // compare before queueing so a same-edge accept never jumps the line
      if (done) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result word %0d err %0b", $realtime, result,
                     operand_error);
        end else begin
          want = pending_words.pop_front();
          if (want.value !== result || want.err !== operand_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: expected result %0d err %0b, got %0d err %0b",
                       $realtime, want.value, want.err, result, operand_error);
          end
        end
      end
      if (start && !busy)
        pending_words.push_back(compute_word(opcode, operand_a, operand_b, exponent,
                                             mod_shadow));
      if (modulus_valid && modulus_ready) mod_shadow = modulus;
    end
  end

endmodule

// ===== tb/sv/modular_arithmetic_alu_test.sv =====
// ----------------------------------------------------------------------------
// modular_arithmetic_alu_test
// Drives directed and random commands into the modular ALU under several
// moduli, with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module modular_arithmetic_alu_test;
  import maa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PHASE_ITEMS = 205;
  localparam longint      CYCLE_LIMIT = 40000000;
  localparam logic [VAL_W-1:0] MOD_MAX = 31'h7FFFFFFF;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [OP_W-1:0]  opcode = '0;
  logic [VAL_W-1:0] operand_a = '0;
  logic [VAL_W-1:0] operand_b = '0;
  logic [EXP_W-1:0] exponent = '0;
  logic             modulus_valid = 1'b0;
  logic [VAL_W-1:0] modulus = '0;
  logic             busy, done, operand_error, modulus_ready;
  logic [VAL_W-1:0] result;
  int               fail_count, outstanding;
  int               items_sent, settings_used;
  longint           cycles = 0;
  logic [VAL_W-1:0] cur_mod;

  modular_arithmetic_alu DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .operand_a(operand_a), .operand_b(operand_b), .exponent(exponent),
    .done(done), .result(result), .operand_error(operand_error),
    .modulus_valid(modulus_valid), .modulus_ready(modulus_ready), .modulus(modulus)
  );

  modular_arithmetic_alu_check checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .operand_a(operand_a), .operand_b(operand_b), .exponent(exponent),
    .done(done), .result(result), .operand_error(operand_error),
    .modulus_valid(modulus_valid), .modulus_ready(modulus_ready), .modulus(modulus),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                           logic [EXP_W-1:0] k);
    int gap;
    bit took;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    exponent  <= k;
    // busy only moves at rising edges, so its value at the falling edge is what the edge sees
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic set_modulus(logic [VAL_W-1:0] m);
    bit took;
    drain();
    modulus_valid <= 1'b1;
    modulus       <= m;
    do begin
      @(negedge clk);
      took = modulus_ready;
      @(posedge clk);
    end while (!took);
    modulus_valid <= 1'b0;
    cur_mod = m;
    settings_used++;
  endtask

  function automatic logic [VAL_W-1:0] pick_operand();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return cur_mod - 1'b1;
      2:       return (cur_mod == MOD_MAX) ? MOD_MAX : cur_mod;
      3:       return VAL_W'($urandom());
      default: return VAL_W'($urandom_range(0, cur_mod - 1'b1));
    endcase
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return EXP_W'($urandom_range(0, 40));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic random_phase(logic [VAL_W-1:0] m);
    set_modulus(m);
    repeat (PHASE_ITEMS)
      send_word(OP_W'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                pick_exponent());
  endtask

  initial begin
    items_sent = 0;
    settings_used = 0;
    cur_mod = MOD_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners under the reset modulus
    send_word(OP_ADD, cur_mod - 1'b1, cur_mod - 1'b1, '0);
    send_word(OP_SUB, '0, cur_mod - 1'b1, '1);
    send_word(OP_MUL, cur_mod - 1'b1, cur_mod - 1'b1, '0);
    send_word(OP_DIV, 31'd12345, '0, '0);
    send_word(OP_DIV, 31'd5, 31'd3, '0);
    send_word(OP_NEG, '0, MOD_MAX, '0);
    send_word(OP_NEG, cur_mod - 1'b1, '0, '0);
    send_word(OP_INV, '0, '0, '0);
    send_word(OP_INV, 31'd1, '0, '0);
    send_word(OP_INV, cur_mod - 1'b1, '0, '0);
    send_word(OP_POW, 31'd7, '0, '0);
    send_word(OP_POW, '0, '0, '0);
    send_word(OP_POW, cur_mod - 1'b1, MOD_MAX, '1);
    send_word(OP_ADD, cur_mod, '0, '0);
    send_word(OP_MUL, 31'd3, MOD_MAX, '0);
    send_word(OP_NEG, cur_mod, '0, '0);
    send_word(OP_UNUSED, MOD_MAX, MOD_MAX, '1);
    // non-coprime and coprime inverse and a non-coprime divide under a composite modulus
    set_modulus(31'd12);
    send_word(OP_INV, 31'd8, '0, '0);
    send_word(OP_DIV, 31'd3, 31'd4, '0);
    send_word(OP_INV, 31'd5, '0, '0);

    random_phase(MOD_RESET);
    random_phase(31'd2);
    random_phase(MOD_MAX);
    random_phase(VAL_W'($urandom_range(3, 1000)));
    random_phase(31'h40000000);
    random_phase(VAL_W'($urandom_range(2, MOD_MAX)));

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d commands over %0d modulus settings, every opcode and error case.",
             items_sent, settings_used + 1);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatching result words", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
